// File: src/vks_pkg.sv
// Shared types and constants of the velocity key scanner.
`default_nettype none

package vks_pkg;

    // Geometry of the key matrix and widths of the stream fields
    localparam int KEYS_PER_GROUP = 8;
    localparam int NUM_COLUMNS    = 8;
    localparam int MAX_KEYS       = 64;
    localparam int TIMER_BITS     = 16;

    localparam int COL_W      = 3;
    localparam int RAW_W      = 16;
    localparam int CODE_W     = 2;
    localparam int LANE_W     = $clog2(KEYS_PER_GROUP);
    localparam int KEY_W      = 6;
    localparam int KEY_CMP_W  = KEY_W + 1;
    localparam int KIND_W     = 2;
    localparam int VALUE_W    = 16;
    localparam int ACOL_W     = 4;
    localparam int KCNT_W     = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 24;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_MAX      = 2'd2;

    // Register reset values
    localparam logic [ACOL_W-1:0]     ACOL_RESET = 4'd8;
    localparam logic [KCNT_W-1:0]     KCNT_RESET = 7'd64;
    localparam logic [TIMER_BITS-1:0] TMAX_RESET = 16'hFFFF;

    // Contact codes (bit 0 top, bit 1 bottom)
    localparam logic [CODE_W-1:0] CODE_NONE = 2'd0;
    localparam logic [CODE_W-1:0] CODE_TOP  = 2'd1;
    localparam logic [CODE_W-1:0] CODE_BOTH = 2'h3;

    // Key phases
    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_TOP      = 2'd1;
    localparam logic [1:0] PH_WAIT_REL = 2'd2;
    localparam logic [1:0] PH_FINAL    = 2'd3;

    // Event kinds
    localparam logic [KIND_W-1:0] KIND_MAX_ON    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TIMED_ON  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUICK_ON  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TIMED_OFF = 2'd3;

    localparam logic [VALUE_W-1:0] VEL_MAX     = 16'd127;
    localparam logic [VALUE_W-1:0] QUICK_VALUE = 16'd1;

    typedef struct packed {
        logic [ACOL_W-1:0]     active_columns;
        logic [KCNT_W-1:0]     key_count;
        logic [TIMER_BITS-1:0] timer_max;
    } cfg_t;

    // One queued item: a tick or a column sample
    typedef struct packed {
        logic             is_scan;
        logic [COL_W-1:0] column;
        logic [RAW_W-1:0] raw;
    } q_item_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key_index;
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
    } event_t;

    // Per-key record held in the back end's memory
    typedef struct packed {
        logic [1:0]            phase;
        logic [CODE_W-1:0]     prev;
        logic [TIMER_BITS-1:0] start;
    } key_rec_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_FLUSH
    } back_state_t;

endpackage

`default_nettype wire

// File: src/vks_front.sv
// Input side: takes beats and drops samples of columns that are not scanned.
`default_nettype none

module vks_front (
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  req_type,
    input  wire logic [2:0]            column,
    input  wire logic [15:0]           raw_contacts,
    input  wire vks_pkg::cfg_t         cfg,
    input  wire logic                  q_full,
    output logic                       q_push,
    output vks_pkg::q_item_t           q_push_item
);
    import vks_pkg::*;

    logic beat;
    logic col_active;

    assign s_ready = !q_full;
    assign beat    = s_valid && s_ready;

    // Column must lie below both the configured and the fitted column count
    assign col_active = (ACOL_W'(column) < cfg.active_columns)
                     && (ACOL_W'(column) < ACOL_W'(NUM_COLUMNS));

    // Ticks always go through; samples only for active columns
    assign q_push = beat && (!req_type || col_active);

    assign q_push_item.is_scan = req_type;
    assign q_push_item.column  = column;
    assign q_push_item.raw     = raw_contacts;

endmodule

`default_nettype wire

// File: src/vks_queue.sv
// Short FIFO between the front and the back end.
`default_nettype none

module vks_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire vks_pkg::q_item_t  push_item,
    output logic                   full,
    input  wire logic              pop,
    output logic                   pop_valid,
    output vks_pkg::q_item_t       pop_item
);
    import vks_pkg::*;

    q_item_t              store [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg, count_next;
    logic                 do_push, do_pop;

    assign full      = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = store[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // Pointer and fill count
    always_comb begin
        wr_ptr_next = do_push ? Q_PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? Q_PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = Q_CNT_W'(count_reg + 1'b1);
        end else if (do_pop && !do_push) begin
            count_next = Q_CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            store[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// File: src/vks_back.sv
// Back end: tick timer, per-key phase machines over the key memory, event output.
`default_nettype none

module vks_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire vks_pkg::cfg_t     cfg,
    input  wire logic              q_valid,
    input  wire vks_pkg::q_item_t  q_item,
    output logic                   q_pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output vks_pkg::event_t        m_event,
    output logic                   m_last
);
    import vks_pkg::*;

    // Key memory with reset-cleared valid bits
    key_rec_t              rec_mem [MAX_KEYS];
    logic [MAX_KEYS-1:0]   rec_valid_reg;
    key_rec_t              rd_rec_reg;
    logic                  rd_ok_reg;
    logic                  rd_en;
    logic [KEY_W-1:0]      rd_addr;
    logic                  wr_en;
    key_rec_t              wr_rec;

    // Control state
    back_state_t           state_reg, state_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic [RAW_W-1:0]      raw_reg, raw_next;
    logic [LANE_W-1:0]     lane_reg, lane_next;
    logic                  issue_done_reg, issue_done_next;
    logic                  b_valid_reg, b_valid_next;
    logic [LANE_W-1:0]     b_lane_reg, b_lane_next;
    logic                  second_reg, second_next;
    logic                  pend_valid_reg, pend_valid_next;
    event_t                pend_reg, pend_next;
    logic                  m_valid_reg, m_valid_next;
    event_t                m_event_reg, m_event_next;
    logic                  m_last_reg, m_last_next;
    logic [TIMER_BITS-1:0] tick_timer_reg, tick_timer_next;

    // Evaluation of the key in the second stage
    logic [KEY_W-1:0]      b_key;
    logic [CODE_W-1:0]     b_code;
    key_rec_t              b_rec;
    logic                  b_touch;
    logic                  b_run;
    logic [TIMER_BITS-1:0] elapsed;
    logic [1:0]            new_phase;
    logic                  set_start;
    logic [1:0]            n_ev_raw, n_ev;
    logic [KIND_W-1:0]     ev1_kind;
    logic [VALUE_W-1:0]    ev1_value;
    event_t                emit_ev;
    logic                  out_free, emit_ok, emit_fire, b_done, a_fire;

    function automatic logic [KEY_W-1:0] key_of(input logic [COL_W-1:0] col,
                                                input logic [LANE_W-1:0] lane);
        key_of = KEY_W'(KEY_W'(col) + KEY_W'(KEY_W'(lane) * KEYS_PER_GROUP));
    endfunction

    assign b_key  = key_of(col_reg, b_lane_reg);
    assign b_code = raw_reg[{b_lane_reg, 1'b0} +: CODE_W];
    assign b_rec  = rd_ok_reg ? rd_rec_reg : '0;

    // Key is present and its contacts moved; phase machine runs only if fitted
    assign b_touch = (KEY_CMP_W'(b_key) < KEY_CMP_W'(MAX_KEYS)) && (b_code != b_rec.prev);
    assign b_run   = b_touch && (KEY_CMP_W'(b_key) < cfg.key_count);

    // Ticks since start, across one timer wrap
    always_comb begin
        if (tick_timer_reg >= b_rec.start) begin
            elapsed = tick_timer_reg - b_rec.start;
        end else begin
            elapsed = cfg.timer_max - b_rec.start + tick_timer_reg + TIMER_BITS'(1);
        end
    end

    // Net effect of the transition rows; a hard hit from idle gives two events
    always_comb begin
        new_phase = b_rec.phase;
        set_start = 1'b0;
        n_ev_raw  = 2'd0;
        ev1_kind  = KIND_MAX_ON;
        ev1_value = VEL_MAX;
        case (b_rec.phase)
            PH_IDLE: begin
                if (b_code == CODE_TOP) begin
                    set_start = 1'b1;
                    new_phase = PH_TOP;
                end else if (b_code == CODE_BOTH) begin
                    n_ev_raw  = 2'd2;
                    new_phase = PH_WAIT_REL;
                end
            end
            PH_TOP: begin
                if (b_code == CODE_NONE) begin
                    set_start = 1'b1;
                    new_phase = PH_IDLE;
                end else if (b_code == CODE_BOTH) begin
                    n_ev_raw  = 2'd1;
                    ev1_kind  = KIND_TIMED_ON;
                    ev1_value = elapsed;
                    new_phase = PH_WAIT_REL;
                end
            end
            PH_WAIT_REL: begin
                if (b_code == CODE_TOP) begin
                    set_start = 1'b1;
                    new_phase = PH_FINAL;
                end
            end
            PH_FINAL: begin
                if (b_code == CODE_BOTH) begin
                    n_ev_raw  = 2'd1;
                    ev1_kind  = KIND_QUICK_ON;
                    ev1_value = QUICK_VALUE;
                    new_phase = PH_WAIT_REL;
                end else if (b_code == CODE_NONE) begin
                    n_ev_raw  = 2'd1;
                    ev1_kind  = KIND_TIMED_OFF;
                    ev1_value = elapsed;
                    new_phase = PH_IDLE;
                end
            end
            default: begin
                new_phase = b_rec.phase;
            end
        endcase
        n_ev = b_run ? n_ev_raw : 2'd0;
    end

    // Record written back once the key has finished
    always_comb begin
        wr_rec.prev  = b_code;
        wr_rec.phase = b_run ? new_phase : b_rec.phase;
        wr_rec.start = (b_run && set_start) ? tick_timer_reg : b_rec.start;
    end

    // Second event of a hard hit is the timed note-on
    always_comb begin
        emit_ev.key_index = b_key;
        if (n_ev == 2'd2 && second_reg) begin
            emit_ev.kind  = KIND_TIMED_ON;
            emit_ev.value = elapsed;
        end else begin
            emit_ev.kind  = ev1_kind;
            emit_ev.value = ev1_value;
        end
    end

    // Handshake between the stages and the output register
    assign out_free  = !m_valid_reg || m_ready;
    assign emit_ok   = !pend_valid_reg || out_free;
    assign emit_fire = (state_reg == BK_SCAN) && b_valid_reg && (n_ev != 2'd0) && emit_ok;
    assign b_done    = (state_reg == BK_SCAN) && b_valid_reg
                    && ((n_ev == 2'd0) || (emit_ok && ((n_ev == 2'd1) || second_reg)));
    assign a_fire    = (state_reg == BK_SCAN) && !issue_done_reg && (!b_valid_reg || b_done);
    assign rd_en     = a_fire;
    assign rd_addr   = key_of(col_reg, lane_reg);
    assign wr_en     = b_done && b_touch;

    // Sequencer: next state and next register values
    always_comb begin
        state_next      = state_reg;
        col_next        = col_reg;
        raw_next        = raw_reg;
        lane_next       = lane_reg;
        issue_done_next = issue_done_reg;
        b_valid_next    = b_valid_reg;
        b_lane_next     = b_lane_reg;
        second_next     = second_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_event_next    = m_event_reg;
        m_last_next     = m_last_reg;
        tick_timer_next = tick_timer_reg;
        q_pop           = 1'b0;

        case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    if (q_item.is_scan) begin
                        col_next        = q_item.column;
                        raw_next        = q_item.raw;
                        lane_next       = '0;
                        issue_done_next = 1'b0;
                        state_next      = BK_SCAN;
                    end else if (tick_timer_reg >= cfg.timer_max) begin
                        tick_timer_next = '0;
                    end else begin
                        tick_timer_next = TIMER_BITS'(tick_timer_reg + 1'b1);
                    end
                end
            end
            BK_SCAN: begin
                // A new event parks in the pending slot; the older one goes out
                if (emit_fire) begin
                    pend_next       = emit_ev;
                    pend_valid_next = 1'b1;
                    if (pend_valid_reg) begin
                        m_valid_next = 1'b1;
                        m_event_next = pend_reg;
                        m_last_next  = 1'b0;
                    end
                    if (n_ev == 2'd2 && !second_reg) begin
                        second_next = 1'b1;
                    end
                end
                if (b_done) begin
                    second_next = 1'b0;
                end
                // Read of the next lane overlaps evaluation of this one
                if (a_fire) begin
                    b_valid_next = 1'b1;
                    b_lane_next  = lane_reg;
                    lane_next    = LANE_W'(lane_reg + 1'b1);
                    if (lane_reg == LANE_W'(KEYS_PER_GROUP - 1)) begin
                        issue_done_next = 1'b1;
                    end
                end else if (b_done) begin
                    b_valid_next = 1'b0;
                end
                if (issue_done_reg && b_done) begin
                    state_next = BK_FLUSH;
                end
            end
            BK_FLUSH: begin
                // Held event is the final one of this scan
                if (!pend_valid_reg) begin
                    state_next = BK_IDLE;
                end else if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_event_next    = pend_reg;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BK_IDLE;
            issue_done_reg <= 1'b0;
            b_valid_reg    <= 1'b0;
            second_reg     <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            tick_timer_reg <= '0;
            lane_reg       <= '0;
        end else begin
            state_reg      <= state_next;
            issue_done_reg <= issue_done_next;
            b_valid_reg    <= b_valid_next;
            second_reg     <= second_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
            tick_timer_reg <= tick_timer_next;
            lane_reg       <= lane_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        col_reg     <= col_next;
        raw_reg     <= raw_next;
        b_lane_reg  <= b_lane_next;
        pend_reg    <= pend_next;
        m_event_reg <= m_event_next;
        m_last_reg  <= m_last_next;
    end

    // Valid bits: an entry never written reads as the reset record
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_valid_reg <= '0;
        end else if (wr_en) begin
            rec_valid_reg[b_key] <= 1'b1;
        end
    end

    // Key memory: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rec_mem[b_key] <= wr_rec;
        end
        if (rd_en) begin
            rd_rec_reg <= rec_mem[rd_addr];
            rd_ok_reg  <= rec_valid_reg[rd_addr];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_event = m_event_reg;
    assign m_last  = m_last_reg;

endmodule

`default_nettype wire

// File: src/velocity_key_scanner_unit.sv
// Velocity key scanner top level: configuration registers, front, queue and back end.
//
// Input stream (s_*): one beat is either a timer tick (s_tuser = 0) or the contact
// sample of one column (s_tuser = 1), with two contact bits for each of eight lanes.
// Output stream (m_*): one beat per note event; m_tlast marks the final event
// caused by a column sample. Ticks and samples that change nothing give no beat.
// Configuration: cfg_wr_en writes cfg_wr_data into register cfg_wr_index
// (0 active columns, 1 key count, 2 timer maximum); write only while idle.
// Flow: a tick is handled by the back end while idle. A column sample is scanned
// lane by lane; the key memory port serves one lane a cycle when the output keeps
// up, a key that gives two events holds its lane longer, and the read of the next
// lane overlaps evaluation of the current one. The last event is held back in a
// pending slot to carry m_tlast, so with two or more events the first beat goes
// out once the second is made, and a lone event leaves at the end of the scan.
// A four-entry queue lets the input take beats while the back end works.
// Reset: synchronous, aresetn low; clears the timer, all key records (valid bits),
// queue and output, and loads registers with 8 columns, 64 keys, timer max 65535.
// A stalled output (m_tready low) holds the beat; the back end then stalls and
// the queue fills before s_tready falls.
`default_nettype none

module velocity_key_scanner_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [2:0] column, [18:3] raw_contacts, rest zero
    input  wire logic [0:0]  s_tuser,   // [0] req_type
    // Output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [5:0] key_index, [21:6] value, rest zero
    output logic [1:0]       m_tuser,   // [1:0] event_kind
    output logic             m_tlast,
    // Configuration writes
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_wr_index,
    input  wire logic [15:0] cfg_wr_data
);
    import vks_pkg::*;

    cfg_t    cfg_reg;
    logic    q_full, q_push, q_pop, q_valid;
    q_item_t q_push_item, q_item;
    event_t  m_event;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.active_columns <= ACOL_RESET;
            cfg_reg.key_count      <= KCNT_RESET;
            cfg_reg.timer_max      <= TMAX_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_ACTIVE_COLUMNS: cfg_reg.active_columns <= cfg_wr_data[ACOL_W-1:0];
                CFG_KEY_COUNT:      cfg_reg.key_count      <= cfg_wr_data[KCNT_W-1:0];
                CFG_TIMER_MAX:      cfg_reg.timer_max      <= cfg_wr_data[TIMER_BITS-1:0];
                default: begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    vks_front u_front (
        .s_valid      (s_tvalid),
        .s_ready      (s_tready),
        .req_type     (s_tuser[0]),
        .column       (s_tdata[COL_W-1:0]),
        .raw_contacts (s_tdata[COL_W +: RAW_W]),
        .cfg          (cfg_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_push_item  (q_push_item)
    );

    vks_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (q_item)
    );

    vks_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_event (m_event),
        .m_last  (m_tlast)
    );

    // Output beat packing
    assign m_tdata = {{(M_TDATA_W - KEY_W - VALUE_W){1'b0}}, m_event.value, m_event.key_index};
    assign m_tuser = m_event.kind;

endmodule

`default_nettype wire

// File: dv/tb.sv
// Self-checking testbench for the velocity key scanner: stream stimulus, note prediction, checks.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vks_pkg::*;

    localparam int LIMIT       = 400_000;  // watchdog, in clock cycles
    localparam int SETTLE      = 64;       // covers a full queue of samples that emit nothing
    localparam int HOLD_CYCLES = 300;      // long receiver stall
    localparam int ERR_REPORT  = 10;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_SCAN = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        logic               last;
    } note_t;

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  s_tvalid     = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata      = '0;
    logic [0:0]            s_tuser      = '0;
    logic                  m_tvalid;
    logic                  m_tready     = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [KIND_W-1:0]     m_tuser;
    logic                  m_tlast;
    logic                  cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_wr_index = CFG_ACTIVE_COLUMNS;
    logic [CFG_DATA_W-1:0] cfg_wr_data  = '0;

    // Shadow of the scanner state
    cfg_t                  cfg_shadow;
    logic [1:0]            key_ph[MAX_KEYS];
    logic [TIMER_BITS-1:0] key_t0[MAX_KEYS];
    logic [CODE_W-1:0]     key_code[MAX_KEYS];
    logic [TIMER_BITS-1:0] timer_now;

    note_t pending_notes[$];

    bit tx_gaps  = 1'b1;
    bit rx_gaps  = 1'b1;
    bit hold_req = 1'b0;
    int rx_held;
    int n_faults    = 0;
    int notes_seen  = 0;
    int scans_sent  = 0;
    int ticks_sent  = 0;
    int cycle_cnt   = 0;

    velocity_key_scanner_unit u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        while (cycle_cnt < LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Note predictor
    // ------------------------------------------------------------------

    function automatic logic [VALUE_W-1:0] ticks_since(input logic [TIMER_BITS-1:0] from);
        if (timer_now >= from)
            return timer_now - from;
        else
            return cfg_shadow.timer_max - from + timer_now + 16'd1;
    endfunction

    function automatic void advance_timer();
        if (timer_now >= cfg_shadow.timer_max)
            timer_now = '0;
        else
            timer_now = timer_now + 1'b1;
    endfunction

    function automatic void push_note(input int key, input logic [KIND_W-1:0] kind,
                                      input logic [VALUE_W-1:0] value);
        note_t n;
        n.key   = KEY_W'(key);
        n.kind  = kind;
        n.value = value;
        n.last  = 1'b0;
        pending_notes.push_back(n);
    endfunction

    // Walk the transition rows in order for every changed key of the column below the key count
    function automatic void predict_scan(input logic [COL_W-1:0] col,
                                         input logic [RAW_W-1:0] raw);
        int                n_prior;
        int                key;
        logic [CODE_W-1:0] code;
        n_prior = pending_notes.size();
        if (col >= cfg_shadow.active_columns || col >= NUM_COLUMNS)
            return;
        for (int lane = 0; lane < KEYS_PER_GROUP; lane++) begin
            key  = col + lane * KEYS_PER_GROUP;
            code = raw[2*lane +: CODE_W];
            if (key >= MAX_KEYS || code == key_code[key])
                continue;
            key_code[key] = code;
            if (key >= cfg_shadow.key_count)
                continue;
            if (key_ph[key] == PH_IDLE && code == CODE_TOP) begin
                key_t0[key] = timer_now;
                key_ph[key] = PH_TOP;
            end
            if (key_ph[key] == PH_IDLE && code == CODE_BOTH) begin
                push_note(key, KIND_MAX_ON, VEL_MAX);
                key_ph[key] = PH_TOP;
            end
            if (key_ph[key] == PH_TOP && code == CODE_NONE) begin
                key_t0[key] = timer_now;
                key_ph[key] = PH_IDLE;
            end
            // a hard hit from idle falls through to here as well
            if (key_ph[key] == PH_TOP && code == CODE_BOTH) begin
                push_note(key, KIND_TIMED_ON, ticks_since(key_t0[key]));
                key_ph[key] = PH_WAIT_REL;
            end
            if (key_ph[key] == PH_WAIT_REL && code == CODE_TOP) begin
                key_t0[key] = timer_now;
                key_ph[key] = PH_FINAL;
            end
            if (key_ph[key] == PH_FINAL && code == CODE_BOTH) begin
                push_note(key, KIND_QUICK_ON, QUICK_VALUE);
                key_ph[key] = PH_WAIT_REL;
            end
            if (key_ph[key] == PH_FINAL && code == CODE_NONE) begin
                push_note(key, KIND_TIMED_OFF, ticks_since(key_t0[key]));
                key_ph[key] = PH_IDLE;
            end
        end
        if (pending_notes.size() > n_prior)
            pending_notes[pending_notes.size()-1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stalls, one long hold, and the checker
    // ------------------------------------------------------------------

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                hold_req = 1'b0;
                for (rx_held = 0; rx_held < HOLD_CYCLES; rx_held++)
                    @(posedge aclk);
            end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 3)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : check_beats
        note_t got;
        note_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.key   = m_tdata[KEY_W-1:0];
            got.value = m_tdata[KEY_W +: VALUE_W];
            got.kind  = m_tuser;
            got.last  = m_tlast;
            notes_seen++;
            if (pending_notes.size() == 0) begin
                n_faults++;
                if (n_faults <= ERR_REPORT)
                    $display("tb: unexpected beat: key %0d kind %0d value %0d last %0b",
                             got.key, got.kind, got.value, got.last);
            end else begin
                want = pending_notes.pop_front();
                if (got.key !== want.key || got.kind !== want.kind ||
                    got.value !== want.value || got.last !== want.last) begin
                    n_faults++;
                    if (n_faults <= ERR_REPORT) begin
                        $display("tb: mismatch at event %0d: expected key %0d kind %0d value %0d last %0b",
                                 notes_seen, want.key, want.kind, want.value, want.last);
                        $display("tb:   got key %0d kind %0d value %0d last %0b",
                                 got.key, got.kind, got.value, got.last);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    task automatic hold_sender(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // Offer one beat, wait for it to be taken, then update the shadow state
    task automatic send_item(input logic req, input logic [COL_W-1:0] col,
                             input logic [RAW_W-1:0] raw);
        if (tx_gaps && $urandom_range(0, 3) == 0)
            hold_sender($urandom_range(1, 4));
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {{(S_TDATA_W-COL_W-RAW_W){1'b0}}, raw, col};
        do @(posedge aclk); while (!s_tready);
        if (req == REQ_SCAN) begin
            predict_scan(col, raw);
            scans_sent++;
        end else begin
            advance_timer();
            ticks_sent++;
        end
    endtask

    task automatic send_scan(input int col, input logic [RAW_W-1:0] raw);
        send_item(REQ_SCAN, COL_W'(col), raw);
    endtask

    // Tick beats carry random, ignored payload
    task automatic send_tick();
        send_item(REQ_TICK, COL_W'($urandom_range(0, 7)), RAW_W'($urandom_range(0, 16'hFFFF)));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_notes.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Writes all three registers back to back once the block is idle
    task automatic set_config(input int ac, input int kc, input int tm);
        wait_drained();
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= CFG_ACTIVE_COLUMNS;
        cfg_wr_data  <= CFG_DATA_W'(ac);
        @(posedge aclk);
        cfg_wr_index <= CFG_KEY_COUNT;
        cfg_wr_data  <= CFG_DATA_W'(kc);
        @(posedge aclk);
        cfg_wr_index <= CFG_TIMER_MAX;
        cfg_wr_data  <= CFG_DATA_W'(tm);
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        cfg_shadow.active_columns = ACOL_W'(ac);
        cfg_shadow.key_count      = KCNT_W'(kc);
        cfg_shadow.timer_max      = TIMER_BITS'(tm);
    endtask

    // Mostly the next step of a real key stroke, sometimes noise or no change
    function automatic logic [CODE_W-1:0] stroke_code(input int key);
        int roll;
        roll = $urandom_range(0, 15);
        if (key >= cfg_shadow.key_count || roll == 0)
            return CODE_W'($urandom_range(0, 3));
        if (roll < 5)
            return key_code[key];
        case (key_ph[key])
            PH_IDLE:     return (roll < 13) ? CODE_TOP : CODE_BOTH;
            PH_TOP:      return (roll < 12) ? CODE_BOTH : CODE_NONE;
            PH_WAIT_REL: return (roll < 13) ? CODE_TOP : CODE_BOTH;
            default:     return (roll < 10) ? CODE_BOTH : CODE_NONE;
        endcase
    endfunction

    function automatic logic [RAW_W-1:0] stroke_column(input int col);
        logic [RAW_W-1:0] raw;
        for (int lane = 0; lane < KEYS_PER_GROUP; lane++)
            raw[2*lane +: CODE_W] = stroke_code(col + lane * KEYS_PER_GROUP);
        return raw;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Transition rows but top to none, hard hit, bottom-only contact, a full column
    task automatic test_directed_notes();
        send_scan(0, 16'h0001);
        send_tick();
        send_tick();
        send_scan(0, 16'h0003);
        send_scan(0, 16'h0001);
        send_scan(0, 16'h0003);
        send_scan(0, 16'h0001);
        send_tick();
        send_scan(0, 16'h0000);
        send_scan(7, 16'hC000);
        send_scan(1, 16'h0002);
        send_scan(1, 16'h0002);
        send_scan(2, 16'hFFFF);
        send_scan(2, 16'h5555);
        send_scan(2, 16'h0000);
    endtask

    // Register values of one: ignored columns, unfitted keys, timer wrap
    task automatic test_register_extremes();
        set_config(1, 1, 1);
        send_scan(1, 16'h0003);
        send_scan(7, 16'hFFFF);
        send_tick();
        send_scan(0, 16'h0005);
        send_tick();
        send_scan(0, 16'h000F);
        send_scan(0, 16'h0000);
    endtask

    // Receiver stalls long while samples keep coming; then the sender waits
    task automatic test_output_backpressure();
        set_config(8, 64, 65535);
        hold_req = 1'b1;
        for (int c = 0; c < NUM_COLUMNS; c++) begin
            send_scan(c, 16'hFFFF);
            send_scan(c, 16'h5555);
            send_scan(c, 16'h0000);
        end
        wait_drained();
    endtask

    task automatic run_random(input int n_items);
        int r;
        int col;
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(0, 99);
            if (r < 35) begin
                send_tick();
            end else if (r < 85) begin
                if ($urandom_range(0, 9) == 0)
                    col = $urandom_range(0, 7);
                else
                    col = $urandom_range(0, int'(cfg_shadow.active_columns) - 1);
                send_scan(col, stroke_column(col));
            end else begin
                send_scan($urandom_range(0, 7), RAW_W'($urandom_range(0, 16'hFFFF)));
            end
        end
    endtask

    // Several register settings; the last phase runs with no idling
    task automatic test_random_play();
        int acs[5];
        int kcs[5];
        int tms[5];
        acs = '{8, 3, 1, 8, 6};
        kcs = '{64, 20, 1, 64, 40};
        tms = '{65535, 50, 1, 9, 200};
        for (int p = 0; p < 5; p++) begin
            set_config(acs[p], kcs[p], tms[p]);
            if (p == 4) begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end
            run_random(80);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        cfg_shadow = '{active_columns: ACOL_RESET, key_count: KCNT_RESET, timer_max: TMAX_RESET};
        timer_now  = '0;
        for (int k = 0; k < MAX_KEYS; k++) begin
            key_ph[k]   = PH_IDLE;
            key_t0[k]   = '0;
            key_code[k] = CODE_NONE;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_notes();
        test_register_extremes();
        test_output_backpressure();
        test_random_play();

        wait_drained();
        $display("tb: %0d column samples and %0d ticks sent, %0d note events checked",
                 scans_sent, ticks_sent, notes_seen);
        $display("tb: covered all key phases, hard hits, timer wrap, ignored keys, long stall");
        if (n_faults == 0 && pending_notes.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
